[hdl/cesd_pkg.sv]
// ----------------------------------------------------------------------------
// cesd_pkg
// shared types, constants and character helpers of the escape string decoder
// ----------------------------------------------------------------------------
package cesd_pkg;

	localparam int BUFFER_SIZE = 32;
	localparam int CNT_W       = $clog2(BUFFER_SIZE);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUFFER_SIZE - 1);

	localparam int LEN_W     = 5;
	localparam int TDATA_W   = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W    = PTR_W + 1;

	// escape modes
	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_ESC    = 3'd1;
	localparam logic [2:0] MODE_OCT1   = 3'd2;
	localparam logic [2:0] MODE_OCT2   = 3'd3;
	localparam logic [2:0] MODE_HEX0   = 3'd4;
	localparam logic [2:0] MODE_HEX1   = 3'd5;

	// end reasons
	localparam logic [1:0] REASON_SPACE = 2'd0;
	localparam logic [1:0] REASON_NUL   = 2'd1;
	localparam logic [1:0] REASON_FULL  = 2'd2;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LFEED = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;

	localparam logic [8:0] VAL_X = 9'h078;

	typedef struct packed {
		logic             last;
		logic             is_end;
		logic [1:0]       reason;
		logic [LEN_W-1:0] len;
		logic [7:0]       out_byte;
	} res_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_SEVEN);
	endfunction

	function automatic logic hex_ok(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF)
			|| (c >= CH_UA && c <= CH_UF);
	endfunction

	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = c - CH_LA + 8'd10;
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UA + 8'd10;
		end
		return d[3:0];
	endfunction

endpackage

[hdl/cesd_decode.sv]
// ----------------------------------------------------------------------------
// cesd_decode
// next-state and result logic for one source character
// ----------------------------------------------------------------------------
module cesd_decode (
	input  logic [7:0]               c,
	input  logic [2:0]               mode,
	input  logic [8:0]               val,
	input  logic [cesd_pkg::CNT_W-1:0] cnt,
	output logic [1:0]               n,
	output cesd_pkg::res_t           r0,
	output cesd_pkg::res_t           r1,
	output logic [2:0]               nmode,
	output logic [8:0]               nval,
	output logic [cesd_pkg::CNT_W-1:0] ncnt
);

	logic                         oct_c;
	logic                         hex_c;
	logic                         flush;
	logic [cesd_pkg::CNT_W-1:0]   fb_cnt;
	logic                         fr_v;
	cesd_pkg::res_t               fr;
	logic [2:0]                   fr_mode;
	logic [cesd_pkg::CNT_W-1:0]   fr_cnt;
	cesd_pkg::res_t               esc_r;
	logic [cesd_pkg::CNT_W-1:0]   cnt_inc;

	assign oct_c   = cesd_pkg::is_oct(c);
	assign hex_c   = cesd_pkg::hex_ok(c);
	assign cnt_inc = cnt + 1'b1;

	assign flush = ((mode == cesd_pkg::MODE_OCT1 || mode == cesd_pkg::MODE_OCT2) && !oct_c)
		|| ((mode == cesd_pkg::MODE_HEX0 || mode == cesd_pkg::MODE_HEX1) && !hex_c);
	assign fb_cnt = flush ? cnt_inc : cnt;

	// plain character handling
	always_comb begin
		fr_v    = 1'b0;
		fr      = '0;
		fr_mode = cesd_pkg::MODE_NORMAL;
		fr_cnt  = fb_cnt;
		if (c == cesd_pkg::CH_NUL) begin
			fr_v      = 1'b1;
			fr.is_end = 1'b1;
			fr.reason = cesd_pkg::REASON_NUL;
			fr.len    = cesd_pkg::LEN_W'(fb_cnt);
			fr_cnt    = '0;
		end else if (cesd_pkg::is_space(c)) begin
			fr_v      = 1'b1;
			fr.is_end = 1'b1;
			fr.reason = cesd_pkg::REASON_SPACE;
			fr.len    = cesd_pkg::LEN_W'(fb_cnt);
			fr_cnt    = '0;
		end else if (fb_cnt >= cesd_pkg::FULL_CNT) begin
			fr_v      = 1'b1;
			fr.is_end = 1'b1;
			fr.reason = cesd_pkg::REASON_FULL;
			fr.len    = cesd_pkg::LEN_W'(fb_cnt);
			fr_cnt    = '0;
		end else if (c == cesd_pkg::CH_BSL) begin
			fr_mode = cesd_pkg::MODE_ESC;
		end else begin
			fr_v        = 1'b1;
			fr_cnt      = fb_cnt + 1'b1;
			fr.out_byte = c;
			fr.len      = cesd_pkg::LEN_W'(fr_cnt);
		end
	end

	// byte produced by a single escape letter
	always_comb begin
		esc_r     = '0;
		esc_r.len = cesd_pkg::LEN_W'(cnt_inc);
		case (c)
			cesd_pkg::CH_N: esc_r.out_byte = cesd_pkg::CH_LFEED;
			cesd_pkg::CH_R: esc_r.out_byte = cesd_pkg::CH_CR;
			cesd_pkg::CH_B: esc_r.out_byte = cesd_pkg::CH_BS;
			cesd_pkg::CH_T: esc_r.out_byte = cesd_pkg::CH_TAB;
			cesd_pkg::CH_F: esc_r.out_byte = cesd_pkg::CH_FF;
			cesd_pkg::CH_V: esc_r.out_byte = cesd_pkg::CH_VT;
			default:        esc_r.out_byte = c;
		endcase
	end

	always_comb begin
		n     = 2'd0;
		r0    = '0;
		r1    = '0;
		nmode = mode;
		nval  = val;
		ncnt  = cnt;
		if (flush) begin
			r0.out_byte = val[7:0];
			r0.len      = cesd_pkg::LEN_W'(cnt_inc);
			r1          = fr;
			n           = fr_v ? 2'd2 : 2'd1;
			nmode       = fr_mode;
			nval        = '0;
			ncnt        = fr_cnt;
		end else begin
			unique case (mode)
				cesd_pkg::MODE_ESC: begin
					nmode = cesd_pkg::MODE_NORMAL;
					nval  = '0;
					if (c == cesd_pkg::CH_NUL) begin
						r0.is_end = 1'b1;
						r0.reason = cesd_pkg::REASON_NUL;
						r0.len    = cesd_pkg::LEN_W'(cnt);
						n         = 2'd1;
						ncnt      = '0;
					end else if (oct_c) begin
						nval  = 9'(c - cesd_pkg::CH_ZERO);
						nmode = cesd_pkg::MODE_OCT1;
					end else if (c == cesd_pkg::CH_X) begin
						nval  = cesd_pkg::VAL_X;
						nmode = cesd_pkg::MODE_HEX0;
					end else begin
						r0   = esc_r;
						n    = 2'd1;
						ncnt = cnt_inc;
					end
				end
				cesd_pkg::MODE_OCT1: begin
					nval  = {val[5:0], c[2:0]};
					nmode = cesd_pkg::MODE_OCT2;
				end
				cesd_pkg::MODE_OCT2: begin
					r0.out_byte = {val[4:0], c[2:0]};
					r0.len      = cesd_pkg::LEN_W'(cnt_inc);
					n           = 2'd1;
					ncnt        = cnt_inc;
					nmode       = cesd_pkg::MODE_NORMAL;
					nval        = '0;
				end
				cesd_pkg::MODE_HEX0: begin
					nval  = {5'd0, cesd_pkg::hex_nib(c)};
					nmode = cesd_pkg::MODE_HEX1;
				end
				cesd_pkg::MODE_HEX1: begin
					r0.out_byte = {val[3:0], cesd_pkg::hex_nib(c)};
					r0.len      = cesd_pkg::LEN_W'(cnt_inc);
					n           = 2'd1;
					ncnt        = cnt_inc;
					nmode       = cesd_pkg::MODE_NORMAL;
					nval        = '0;
				end
				default: begin
					r0    = fr;
					n     = fr_v ? 2'd1 : 2'd0;
					nmode = fr_mode;
					nval  = '0;
					ncnt  = fr_cnt;
				end
			endcase
		end
		if (n == 2'd2) begin
			r1.last = 1'b1;
		end else if (n == 2'd1) begin
			r0.last = 1'b1;
		end
	end

endmodule

[hdl/cesd_res_fifo.sv]
// ----------------------------------------------------------------------------
// cesd_res_fifo
// small result queue taking up to two results per cycle, one out per cycle
// ----------------------------------------------------------------------------
module cesd_res_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push,
	input  cesd_pkg::res_t                w0,
	input  cesd_pkg::res_t                w1,
	input  logic                          pop,
	output cesd_pkg::res_t                head,
	output logic                          not_empty,
	output logic [cesd_pkg::FCNT_W-1:0]   free
);

	cesd_pkg::res_t                 buf_q [cesd_pkg::FIFO_DEPTH];
	logic [cesd_pkg::PTR_W-1:0]     wr_q;
	logic [cesd_pkg::PTR_W-1:0]     rd_q;
	logic [cesd_pkg::FCNT_W-1:0]    cnt_q;
	logic [cesd_pkg::PTR_W-1:0]     wr_nxt;

	assign wr_nxt    = wr_q + 1'b1;
	assign head      = buf_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign free      = cesd_pkg::FCNT_W'(cesd_pkg::FIFO_DEPTH) - cnt_q;

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			buf_q[wr_q] <= w0;
		end
		if (push == 2'd2) begin
			buf_q[wr_nxt] <= w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + cesd_pkg::PTR_W'(push);
			rd_q  <= rd_q + cesd_pkg::PTR_W'(pop);
			cnt_q <= cnt_q + cesd_pkg::FCNT_W'(push) - cesd_pkg::FCNT_W'(pop);
		end
	end

endmodule

[hdl/c_escape_string_decoder.sv]
// ----------------------------------------------------------------------------
// c_escape_string_decoder
// decodes C escape sequences in a character stream into bytes
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one source character per transaction in s_tdata.
//   m_* gives decoded bytes and end-of-string records; m_tuser is 1 for an
//   end record, m_tlast marks the final result caused by one character.
//   a character is registered in an input stage, decoded combinationally,
//   and its zero, one or two results are written to a four-entry result queue.
//   m_tvalid comes from the queue count register, behind the input stage.
//   throughput: one character per cycle while the queue has room for the
//   results of the character in the input stage; set by the single queue
//   read port, so a character that yields two results needs one extra
//   output transfer.
//   when the receiver stalls the queue fills and s_tready drops; s_tready
//   depends on registers only.
//   reset clears the input stage, the queue and the escape state; the block
//   starts in normal mode with an empty string.
// ----------------------------------------------------------------------------
module c_escape_string_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // char_in
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cesd_pkg::TDATA_W-1:0] m_tdata,  // out_byte, end_reason, length
	output logic                         m_tuser,  // is_end
	output logic                         m_tlast
);

	logic                           valid_s1;
	logic [7:0]                     char_s1;
	logic [2:0]                     mode_q;
	logic [8:0]                     value_q;
	logic [cesd_pkg::CNT_W-1:0]     count_q;

	logic [1:0]                     n;
	cesd_pkg::res_t                 r0;
	cesd_pkg::res_t                 r1;
	logic [2:0]                     nmode;
	logic [8:0]                     nval;
	logic [cesd_pkg::CNT_W-1:0]     ncnt;

	logic                           adv;
	logic [1:0]                     push;
	logic                           pop;
	cesd_pkg::res_t                 head;
	logic                           not_empty;
	logic [cesd_pkg::FCNT_W-1:0]    free;

	cesd_decode u_decode (
		.c     (char_s1),
		.mode  (mode_q),
		.val   (value_q),
		.cnt   (count_q),
		.n     (n),
		.r0    (r0),
		.r1    (r1),
		.nmode (nmode),
		.nval  (nval),
		.ncnt  (ncnt)
	);

	assign adv      = valid_s1 && (cesd_pkg::FCNT_W'(n) <= free);
	assign push     = adv ? n : 2'd0;
	assign s_tready = !valid_s1 || adv;
	assign pop      = not_empty && m_tready;

	cesd_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.w0        (r0),
		.w1        (r1),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.free      (free)
	);

	assign m_tvalid = not_empty;
	assign m_tdata  = {1'b0, head.len, head.reason, head.out_byte};
	assign m_tuser  = head.is_end;
	assign m_tlast  = head.last;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= cesd_pkg::MODE_NORMAL;
			value_q  <= '0;
			count_q  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				mode_q  <= nmode;
				value_q <= nval;
				count_q <= ncnt;
			end
		end
	end

`ifndef SYNTH
	a_esc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != cesd_pkg::MODE_NORMAL |-> count_q < cesd_pkg::FULL_CNT)
		else $error("escape pending with full buffer");

	a_normal_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == cesd_pkg::MODE_NORMAL |-> value_q == '0)
		else $error("escape value not cleared in normal mode");

	a_end_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ((n != 2'd0 && r0.is_end) || (n == 2'd2 && r1.is_end))
		|=> count_q == '0)
		else $error("byte count not cleared after end of string");

	a_two_results_order: assert property (@(posedge clk) disable iff (!arst_n)
		adv && n == 2'd2 |-> !r0.last && r1.last && !r0.is_end)
		else $error("bad result pair");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stream testbench of c_escape_string_decoder: directed escapes, then random
// well-formed strings mixed with noise bytes, under three idling schedules and
// a long receiver stall; every output transaction is checked field by field
// against an in-bench decoder
// ----------------------------------------------------------------------------
module tb_top;

	localparam int         HOLD_CYCLES = 64;
	localparam logic [1:0] NO_REASON   = 2'd0;

	typedef struct packed {
		logic                       pad;
		logic [cesd_pkg::LEN_W-1:0] len;
		logic [1:0]                 reason;
		logic [7:0]                 out_byte;
		logic                       is_end;
		logic                       last;
	} dec_res_t;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata  = 8'h00;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [cesd_pkg::TDATA_W-1:0]  m_tdata;  // out_byte, end_reason, length, zero pad
	logic                          m_tuser;  // is_end
	logic                          m_tlast;

	logic [7:0] pending_chars [$];
	dec_res_t   expected_res [$];
	int         queued      = 0;
	int         errors      = 0;
	int         tx_idle_pct = 0;
	int         rx_idle_pct = 0;
	logic       hold_go     = 1'b0;
	int         hold_left;

	// decoder state
	logic [2:0] esc_mode = cesd_pkg::MODE_NORMAL;
	logic [8:0] esc_val  = 9'd0;
	logic [5:0] str_len  = 6'd0;

	c_escape_string_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// decoder prediction
	// ------------------------------------------------------------------
	function automatic logic is_blank(input logic [7:0] c);
		return c == cesd_pkg::CH_SP || (c >= cesd_pkg::CH_TAB && c <= cesd_pkg::CH_CR);
	endfunction

	function automatic logic is_oct_digit(input logic [7:0] c);
		return c >= cesd_pkg::CH_ZERO && c <= cesd_pkg::CH_SEVEN;
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= cesd_pkg::CH_ZERO && c <= cesd_pkg::CH_NINE)
			return int'(c) - int'(cesd_pkg::CH_ZERO);
		if (c >= cesd_pkg::CH_LA && c <= cesd_pkg::CH_LF)
			return int'(c) - int'(cesd_pkg::CH_LA) + 10;
		if (c >= cesd_pkg::CH_UA && c <= cesd_pkg::CH_UF)
			return int'(c) - int'(cesd_pkg::CH_UA) + 10;
		return -1;
	endfunction

	task automatic expect_result(input logic [7:0] b, input logic e, input logic [1:0] r);
		dec_res_t x;
		x.pad      = 1'b0;
		x.len      = str_len[cesd_pkg::LEN_W-1:0];
		x.reason   = r;
		x.out_byte = b;
		x.is_end   = e;
		x.last     = 1'b0;
		expected_res.push_back(x);
	endtask

	task automatic add_byte(input logic [7:0] b);
		str_len = str_len + 6'd1;
		expect_result(b, 1'b0, NO_REASON);
	endtask

	task automatic end_string(input logic [1:0] r);
		expect_result(8'h00, 1'b1, r);
		esc_mode = cesd_pkg::MODE_NORMAL;
		esc_val  = 9'd0;
		str_len  = 6'd0;
	endtask

	task automatic fresh_char(input logic [7:0] c);
		if (c == cesd_pkg::CH_NUL) begin
			end_string(cesd_pkg::REASON_NUL);
		end else if (is_blank(c)) begin
			end_string(cesd_pkg::REASON_SPACE);
		end else if (str_len >= 6'(cesd_pkg::BUFFER_SIZE - 1)) begin
			end_string(cesd_pkg::REASON_FULL);
		end else if (c == cesd_pkg::CH_BSL) begin
			esc_mode = cesd_pkg::MODE_ESC;
		end else begin
			add_byte(c);
		end
	endtask

	// a non-digit cuts the escape short: emit its value, then take c anew
	task automatic flush_escape(input logic [7:0] c);
		logic [8:0] v;
		v        = esc_val;
		esc_mode = cesd_pkg::MODE_NORMAL;
		esc_val  = 9'd0;
		add_byte(v[7:0]);
		fresh_char(c);
	endtask

	task automatic decode_char(input logic [7:0] c);
		int         h;
		int         n0;
		logic [8:0] v;
		dec_res_t   tail;
		n0 = expected_res.size();
		h  = hex_digit(c);
		case (esc_mode)
			cesd_pkg::MODE_ESC: begin
				esc_mode = cesd_pkg::MODE_NORMAL;
				esc_val  = 9'd0;
				if (c == cesd_pkg::CH_NUL) end_string(cesd_pkg::REASON_NUL);
				else if (c == cesd_pkg::CH_N) add_byte(cesd_pkg::CH_LFEED);
				else if (c == cesd_pkg::CH_R) add_byte(cesd_pkg::CH_CR);
				else if (c == cesd_pkg::CH_B) add_byte(cesd_pkg::CH_BS);
				else if (c == cesd_pkg::CH_T) add_byte(cesd_pkg::CH_TAB);
				else if (c == cesd_pkg::CH_F) add_byte(cesd_pkg::CH_FF);
				else if (c == cesd_pkg::CH_V) add_byte(cesd_pkg::CH_VT);
				else if (is_oct_digit(c)) begin
					esc_val  = 9'(c - cesd_pkg::CH_ZERO);
					esc_mode = cesd_pkg::MODE_OCT1;
				end else if (c == cesd_pkg::CH_X) begin
					esc_val  = 9'(cesd_pkg::CH_X);
					esc_mode = cesd_pkg::MODE_HEX0;
				end else add_byte(c);
			end
			cesd_pkg::MODE_OCT1: begin
				if (is_oct_digit(c)) begin
					esc_val  = (esc_val << 3) | 9'(c - cesd_pkg::CH_ZERO);
					esc_mode = cesd_pkg::MODE_OCT2;
				end else flush_escape(c);
			end
			cesd_pkg::MODE_OCT2: begin
				if (is_oct_digit(c)) begin
					v        = (esc_val << 3) | 9'(c - cesd_pkg::CH_ZERO);
					esc_mode = cesd_pkg::MODE_NORMAL;
					esc_val  = 9'd0;
					add_byte(v[7:0]);
				end else flush_escape(c);
			end
			cesd_pkg::MODE_HEX0: begin
				if (h >= 0) begin
					esc_val  = 9'(h);
					esc_mode = cesd_pkg::MODE_HEX1;
				end else flush_escape(c);
			end
			cesd_pkg::MODE_HEX1: begin
				if (h >= 0) begin
					v        = (esc_val << 4) + 9'(h);
					esc_mode = cesd_pkg::MODE_NORMAL;
					esc_val  = 9'd0;
					add_byte(v[7:0]);
				end else flush_escape(c);
			end
			default: begin
				esc_mode = cesd_pkg::MODE_NORMAL;
				fresh_char(c);
			end
		endcase
		if (expected_res.size() > n0) begin
			tail      = expected_res.pop_back();
			tail.last = 1'b1;
			expected_res.push_back(tail);
		end
	endtask

	// ------------------------------------------------------------------
	// driver, receiver, monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
		end else if (!s_tvalid || s_tready) begin
			if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_chars.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns  %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		dec_res_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) decode_char(s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_res.size() == 0) begin
					report_mismatch("unexpected transaction", int'(m_tdata), 0);
				end else begin
					want = expected_res.pop_front();
					if (m_tdata[7:0] != want.out_byte)
						report_mismatch("out_byte", int'(m_tdata[7:0]),
							int'(want.out_byte));
					if (m_tdata[9:8] != want.reason)
						report_mismatch("end_reason", int'(m_tdata[9:8]),
							int'(want.reason));
					if (m_tdata[14:10] != want.len)
						report_mismatch("length", int'(m_tdata[14:10]), int'(want.len));
					if (m_tdata[15] != want.pad)
						report_mismatch("tdata pad", int'(m_tdata[15]), int'(want.pad));
					if (m_tuser != want.is_end)
						report_mismatch("is_end", int'(m_tuser), int'(want.is_end));
					if (m_tlast != want.last)
						report_mismatch("is_last", int'(m_tlast), int'(want.last));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic push_char(input logic [7:0] c);
		pending_chars.push_back(c);
		queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i]);
	endtask

	function automatic logic [7:0] rand_hex_char();
		int k;
		k = $urandom_range(21);
		if (k < 10) return cesd_pkg::CH_ZERO + 8'(k);
		if (k < 16) return cesd_pkg::CH_LA + 8'(k - 10);
		return cesd_pkg::CH_UA + 8'(k - 16);
	endfunction

	task automatic push_token();
		logic [7:0] c;
		int         n;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				c = 8'($urandom_range(33, 126));
				push_char(c == cesd_pkg::CH_BSL ? cesd_pkg::CH_X : c);
			end
			4: begin
				push_char(cesd_pkg::CH_BSL);
				case ($urandom_range(5))
					0: push_char(cesd_pkg::CH_N);
					1: push_char(cesd_pkg::CH_R);
					2: push_char(cesd_pkg::CH_B);
					3: push_char(cesd_pkg::CH_T);
					4: push_char(cesd_pkg::CH_F);
					default: push_char(cesd_pkg::CH_V);
				endcase
			end
			5: begin
				push_char(cesd_pkg::CH_BSL);
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					push_char(cesd_pkg::CH_ZERO + 8'($urandom_range(7)));
			end
			6: begin
				push_char(cesd_pkg::CH_BSL);
				push_char(cesd_pkg::CH_X);
				n = $urandom_range(2);
				for (int i = 0; i < n; i++) push_char(rand_hex_char());
			end
			7: begin
				push_char(cesd_pkg::CH_BSL);
				push_char(8'($urandom_range(255)));
			end
			default: push_char(8'($urandom_range(128, 255)));
		endcase
	endtask

	task automatic push_random();
		int n;
		if ($urandom_range(4) == 0) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) push_char(8'($urandom_range(255)));
		end else begin
			// now and then a string long enough to fill the buffer
			n = ($urandom_range(5) == 0) ? $urandom_range(28, 40) : $urandom_range(12);
			for (int i = 0; i < n; i++) push_token();
			case ($urandom_range(6))
				0: push_char(cesd_pkg::CH_NUL);
				1: push_char(cesd_pkg::CH_TAB);
				2: push_char(cesd_pkg::CH_LFEED);
				3: push_char(cesd_pkg::CH_VT);
				4: push_char(cesd_pkg::CH_FF);
				5: push_char(cesd_pkg::CH_CR);
				default: push_char(cesd_pkg::CH_SP);
			endcase
		end
	endtask

	task automatic fill_random(input int count);
		int goal;
		goal = queued + count;
		while (queued < goal) push_random();
	endtask

	task automatic wait_drained();
		while (pending_chars.size() != 0 || s_tvalid || expected_res.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 17;
		rx_idle_pct = 82;
		push_char(cesd_pkg::CH_NUL);
		push_char(8'hFF);
		push_text("\\n\\777\\1z\\x \\xAf\\");
		push_char(cesd_pkg::CH_TAB);
		push_char(cesd_pkg::CH_BSL);
		push_char(cesd_pkg::CH_NUL);
		push_text("\\12");
		push_char(cesd_pkg::CH_NUL);
		push_text("\\x9q");
		fill_random(200);
		wait_drained();

		tx_idle_pct = 82;
		rx_idle_pct = 17;
		fill_random(200);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		fill_random(200);
		hold_go = 1'b1;
		@(negedge clk);
		hold_go = 1'b0;
		wait_drained();

		repeat (8) @(posedge clk);
		if (errors == 0 && expected_res.size() == 0) begin
			$display("c_escape_string_decoder: match");
		end else begin
			$display("c_escape_string_decoder: mismatch");
		end
		$finish;
	end

	initial begin
		#2400000;
		$display("c_escape_string_decoder: mismatch");
		$finish;
	end

endmodule
